[hdl/rsenc_pkg.sv]
// shared types, constants and galois field helpers for the reed-solomon parity encoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rsenc_pkg;

  localparam int unsigned MaxRoots = 32;
  localparam int unsigned RootW    = 6;   // holds 1 .. MaxRoots and the raw register value
  localparam int unsigned StepW    = 5;   // holds 0 .. MaxRoots-1
  localparam int unsigned CntW     = 8;

  localparam logic [7:0]       FieldPolyLow    = 8'h1d;  // x^8+x^4+x^3+x^2+1 without x^8
  localparam logic [RootW-1:0] ParityCountRst  = 6'd10;
  localparam logic [CntW-1:0]  FieldN          = 8'd255;

  // register indexes on the configuration port
  localparam logic CfgParityCount = 1'b0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] parity_byte;
    logic       last_out;
    logic       length_error;
  } out_item_t;

  typedef logic [MaxRoots-1:0][7:0] coef_arr_t;

  typedef struct packed {
    logic             start;
    logic [RootW-1:0] roots;
  } gen_ctrl_t;

  // general multiply in gf(256)
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x   = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        acc = acc ^ x;
      end
      x = {x[6:0], 1'b0} ^ (x[7] ? FieldPolyLow : 8'h00);
    end
    return acc;
  endfunction

  // multiply by alpha
  function automatic logic [7:0] gf_mul_alpha(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? FieldPolyLow : 8'h00);
  endfunction

  // clamp the raw register value to 1 .. MaxRoots
  function automatic logic [RootW-1:0] eff_roots(input logic [RootW-1:0] raw);
    logic [RootW-1:0] n;
    n = raw;
    if (raw == '0) begin
      n = RootW'(1);
    end else if (raw > RootW'(MaxRoots)) begin
      n = RootW'(MaxRoots);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

[hdl/rsenc_gen.sv]
// generator polynomial builder: multiplies in one (x + alpha^i) factor per cycle
// depends on rsenc_pkg
`timescale 1ns / 1ps
`default_nettype none

module rsenc_gen (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  rsenc_pkg::gen_ctrl_t     ctrl_i,
  output logic                     busy_o,
  output rsenc_pkg::coef_arr_t     coef_o
);

  // coef_q[k] is generator coefficient of order n-1-k, leading 1 kept implicit
  rsenc_pkg::coef_arr_t                coef_q, coef_d;
  logic                                busy_q, busy_d;
  logic [rsenc_pkg::StepW-1:0]         step_q, step_d;
  logic [7:0]                          root_q, root_d;
  logic [rsenc_pkg::StepW-1:0]         last_step;

  assign last_step = rsenc_pkg::StepW'(ctrl_i.roots - rsenc_pkg::RootW'(1));

  always_comb begin
    coef_d = coef_q;
    busy_d = busy_q;
    step_d = step_q;
    root_d = root_q;
    if (ctrl_i.start) begin
      coef_d = '0;
      busy_d = 1'b1;
      step_d = '0;
      root_d = 8'h01;
    end else if (busy_q) begin
      // reversed-order product with (x + root): r'[j] = r[j] ^ root * r[j-1]
      for (int k = 0; k < rsenc_pkg::MaxRoots; k++) begin
        if (k == 0) begin
          coef_d[k] = coef_q[k] ^ root_q;
        end else begin
          coef_d[k] = coef_q[k] ^ rsenc_pkg::gf_mul(coef_q[k-1], root_q);
        end
      end
      root_d = rsenc_pkg::gf_mul_alpha(root_q);
      step_d = step_q + rsenc_pkg::StepW'(1);
      if (step_q == last_step) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
      busy_q <= 1'b1;
      step_q <= '0;
      root_q <= 8'h01;
    end else begin
      coef_q <= coef_d;
      busy_q <= busy_d;
      step_q <= step_d;
      root_q <= root_d;
    end
  end

  assign busy_o = busy_q;
  assign coef_o = coef_q;

endmodule

`default_nettype wire

[hdl/reed_solomon_parity_encoder_top.sv]
// top level of the systematic reed-solomon parity encoder over gf(256)
// depends on rsenc_pkg and rsenc_gen
`timescale 1ns / 1ps
`default_nettype none

// Systematic Reed-Solomon encoder over GF(256), field polynomial 0x11d, roots alpha^0 upward.
// Message bytes go in one per cycle while in_ready_o is high and update all parity taps in
// parallel. The byte marked last loads the n parity bytes into an output buffer, which sends
// them one per cycle while out_ready_i is high, highest order first, with last_out on the
// final one and length_error set when the message was longer than 255 - n bytes; the next
// codeword's bytes are taken while that buffer drains, but a further last byte waits until
// the buffer is empty. After reset (n = 10) and every parity_count write the generator is
// rebuilt, one factor per cycle; no byte is taken until it is done, nor in a write's access
// cycle or while its start is registered. Register parity_count sits at byte address 0;
// values below 1 act as 1 and above 32 as 32, and a write drops any codeword in progress.
module reed_solomon_parity_encoder_top (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,

  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  rsenc_pkg::in_item_t       in_data_i,

  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output rsenc_pkg::out_item_t      out_data_o,

  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  logic [rsenc_pkg::RootW-1:0] pcount_q;
  logic [rsenc_pkg::RootW-1:0] roots;
  logic                        cfg_wr;

  rsenc_pkg::gen_ctrl_t        gen_ctrl;
  logic                        gen_busy;
  rsenc_pkg::coef_arr_t        coef;

  rsenc_pkg::coef_arr_t        par_q, par_d;
  logic [rsenc_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic                        long_q, long_d;

  rsenc_pkg::coef_arr_t        obuf_q, obuf_d;
  logic [rsenc_pkg::RootW-1:0] left_q, left_d;
  logic                        oerr_q, oerr_d;

  logic                        in_xfer, out_xfer;
  logic [7:0]                  fb;
  rsenc_pkg::coef_arr_t        par_step;
  logic                        long_step;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == rsenc_pkg::CfgParityCount);
  assign prdata = (paddr[2] == rsenc_pkg::CfgParityCount) ?
                  {{(32 - rsenc_pkg::RootW){1'b0}}, pcount_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q <= rsenc_pkg::ParityCountRst;
    end else if (cfg_wr) begin
      pcount_q <= pwdata[rsenc_pkg::RootW-1:0];
    end
  end

  assign roots = rsenc_pkg::eff_roots(pcount_q);

  // the builder sees the new count only in the cycle after the write, so start it from the register
  logic start_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b0;
    end else begin
      start_q <= cfg_wr;
    end
  end

  assign gen_ctrl.start = start_q;
  assign gen_ctrl.roots = roots;

  rsenc_gen u_gen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (gen_ctrl),
    .busy_o (gen_busy),
    .coef_o (coef)
  );

  // handshakes
  assign in_ready_o  = !gen_busy && !start_q && !cfg_wr &&
                       (!in_data_i.last_in || (left_q == '0));
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = (left_q != '0);
  assign out_xfer    = out_valid_o && out_ready_i;

  // parity lanes: p'[k] = p[k+1] ^ fb * coef[k], lanes at or above n stay zero
  assign fb = in_data_i.data_byte ^ par_q[0];

  always_comb begin
    for (int k = 0; k < rsenc_pkg::MaxRoots; k++) begin
      if (k == rsenc_pkg::MaxRoots - 1) begin
        par_step[k] = rsenc_pkg::gf_mul(fb, coef[k]);
      end else begin
        par_step[k] = par_q[k+1] ^ rsenc_pkg::gf_mul(fb, coef[k]);
      end
    end
  end

  assign long_step = long_q ||
                     (cnt_q >= (rsenc_pkg::FieldN - rsenc_pkg::CntW'(roots)));

  always_comb begin
    par_d  = par_q;
    cnt_d  = cnt_q;
    long_d = long_q;
    obuf_d = obuf_q;
    left_d = left_q;
    oerr_d = oerr_q;

    if (out_xfer) begin
      for (int k = 0; k < rsenc_pkg::MaxRoots - 1; k++) begin
        obuf_d[k] = obuf_q[k+1];
      end
      obuf_d[rsenc_pkg::MaxRoots-1] = 8'h00;
      left_d = left_q - rsenc_pkg::RootW'(1);
    end

    if (cfg_wr) begin
      par_d  = '0;
      cnt_d  = '0;
      long_d = 1'b0;
    end else if (in_xfer) begin
      if (in_data_i.last_in) begin
        // end of codeword: hand the remainder to the output buffer
        obuf_d = par_step;
        left_d = roots;
        oerr_d = long_step;
        par_d  = '0;
        cnt_d  = '0;
        long_d = 1'b0;
      end else begin
        par_d  = par_step;
        long_d = long_step;
        if (cnt_q != rsenc_pkg::FieldN) begin
          cnt_d = cnt_q + rsenc_pkg::CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      par_q  <= '0;
      cnt_q  <= '0;
      long_q <= 1'b0;
      left_q <= '0;
      oerr_q <= 1'b0;
    end else begin
      par_q  <= par_d;
      cnt_q  <= cnt_d;
      long_q <= long_d;
      left_q <= left_d;
      oerr_q <= oerr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obuf_q <= obuf_d;
  end

  assign out_data_o.parity_byte  = obuf_q[0];
  assign out_data_o.last_out     = (left_q == rsenc_pkg::RootW'(1));
  assign out_data_o.length_error = oerr_q;

  // a last byte loads exactly n results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_data_i.last_in) |=> (out_valid_o && (left_q == $past(roots))))
    else $error("parity burst length does not match parity count");

  // nothing follows the final parity byte until a new last byte arrives
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && out_data_o.last_out) |=> !out_valid_o)
    else $error("result after final parity byte");

  // no byte is encoded while the generator is being rebuilt
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_busy |-> !in_xfer)
    else $error("byte taken during generator rebuild");

endmodule

`default_nettype wire
